[src/c8_pkg.sv]
package c8_pkg;

  localparam int ADDR_W      = 12;
  localparam int MEM_BYTES   = 4096;
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int COL_W       = $clog2(SCREEN_W);
  localparam int ROW_W       = $clog2(SCREEN_H);
  localparam int FONT_BYTES  = 80;
  localparam int FONT_IDX_W  = $clog2(FONT_BYTES);

  localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

  // full-word system opcodes
  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  // low-byte codes of the EX and FX groups
  localparam logic [7:0] KEY_DOWN     = 8'h9E;
  localparam logic [7:0] KEY_UP       = 8'hA1;
  localparam logic [7:0] FX_GET_DELAY = 8'h07;
  localparam logic [7:0] FX_SET_DELAY = 8'h15;
  localparam logic [7:0] FX_SET_SOUND = 8'h18;
  localparam logic [7:0] FX_ADD_INDEX = 8'h1E;
  localparam logic [7:0] FX_FONT      = 8'h29;
  localparam logic [7:0] FX_BCD       = 8'h33;
  localparam logic [7:0] FX_STORE     = 8'h55;
  localparam logic [7:0] FX_LOAD      = 8'h65;

  typedef enum logic [1:0] {
    OP_WRITE_MEM = 2'd0,
    OP_EXECUTE   = 2'd1,
    OP_READ_ROW  = 2'd2,
    OP_READ_MEM  = 2'd3
  } item_op_t;

  typedef enum logic [3:0] {
    GRP_SYS     = 4'h0,
    GRP_JP      = 4'h1,
    GRP_CALL    = 4'h2,
    GRP_SE_IMM  = 4'h3,
    GRP_SNE_IMM = 4'h4,
    GRP_SE_REG  = 4'h5,
    GRP_LD_IMM  = 4'h6,
    GRP_ADD_IMM = 4'h7,
    GRP_ALU     = 4'h8,
    GRP_SNE_REG = 4'h9,
    GRP_LD_I    = 4'hA,
    GRP_JP_V0   = 4'hB,
    GRP_RND     = 4'hC,
    GRP_DRAW    = 4'hD,
    GRP_KEY     = 4'hE,
    GRP_MISC    = 4'hF
  } grp_t;

  typedef enum logic [3:0] {
    SUB_MOV  = 4'h0,
    SUB_OR   = 4'h1,
    SUB_AND  = 4'h2,
    SUB_XOR  = 4'h3,
    SUB_ADD  = 4'h4,
    SUB_SUB  = 4'h5,
    SUB_SHR  = 4'h6,
    SUB_RSUB = 4'h7,
    SUB_SHL  = 4'hE
  } alu_sub_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_OR,
    ALU_AND,
    ALU_XOR,
    ALU_SHR,
    ALU_SHL
  } alu_op_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_START,
    ST_CAPTURE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_READ_VX,
    ST_READ_VY,
    ST_EXEC,
    ST_WRITE_VX,
    ST_SKIP,
    ST_CLS,
    ST_DRAW_FETCH,
    ST_DRAW_ROW,
    ST_DRAW_XOR,
    ST_DRAW_FLAG,
    ST_BCD_H,
    ST_BCD_R,
    ST_BCD_T,
    ST_BCD_WT,
    ST_BCD_WO,
    ST_STORE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_FINISH,
    ST_DONE
  } st_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // sprite byte msb lands on column sh, wrapping around the row
  function automatic logic [SCREEN_W-1:0] sprite_mask(input logic [7:0] bits,
                                                      input logic [COL_W-1:0] sh);
    logic [SCREEN_W-1:0]   base;
    logic [2*SCREEN_W-1:0] dbl;
    base = '0;
    for (int c = 0; c < 8; c++) begin
      base[c] = bits[7-c];
    end
    dbl = {base, base} << sh;
    return dbl[2*SCREEN_W-1:SCREEN_W];
  endfunction

endpackage

[src/c8_ram.sv]
module c8_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/c8_alu.sv]
module c8_alu (
  input  c8_pkg::alu_op_t op,
  input  logic [15:0]     a,
  input  logic [15:0]     b,
  output logic [15:0]     y,
  output logic            zero
);
  import c8_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      ALU_OR:  y = a | b;
      ALU_AND: y = a & b;
      ALU_XOR: y = a ^ b;
      ALU_SHR: y = a >> 1;
      ALU_SHL: y = a << 1;
      default: y = a;
    endcase
  end

  assign zero = (y == 16'd0);

endmodule

[src/chip8_instruction_core.sv]
// each item runs as a short pass for a write or a memory or row read; execute
//   fetches, reads operands, runs and finishes, with extra steps for a skip or flag
//   write, FX33, 00E0, DXYN, FX55 and FX65, then the result loads
// throughput: one item at a time, next item taken the cycle after the result loads
//   (the single shared alu and the one-port main memory set the pace)
// reset: after rst_n the core sweeps all 4096 memory bytes (font at 0-79) and the
//   32 display rows with in_ready low; registers, stack, timers clear
module chip8_instruction_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [c8_pkg::ADDR_W-1:0]     in_address,
  input  logic [7:0]                    in_write_data,
  input  logic [15:0]                   in_keys,
  input  logic [7:0]                    in_random_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_mem_data,
  output logic [c8_pkg::SCREEN_W-1:0]   out_row_pixels,
  output logic [c8_pkg::ADDR_W-1:0]     out_prog_counter,
  output logic [15:0]                   out_executed_opcode,
  output logic [7:0]                    out_flag_value,
  output logic                          out_screen_changed,
  output logic                          out_sound_active,
  output logic                          out_bad_opcode
);
  import c8_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH);

  // sequencer and latched item
  st_t                state_r, state_nxt;
  item_op_t           op_r, op_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [7:0]         wdata_r, wdata_nxt;
  logic [15:0]        keys_r, keys_nxt;
  logic [7:0]         rnd_r, rnd_nxt;

  // architectural state
  logic [ADDR_W-1:0]  pc_r, pc_nxt;
  logic [15:0]        index_r, index_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [7:0]         delay_r, delay_nxt;
  logic [7:0]         sound_r, sound_nxt;
  logic [7:0]         rf_r [16];
  logic [ADDR_W-1:0]  stack_r [STACK_DEPTH];

  // working registers
  logic [15:0]        opc_r, opc_nxt;
  logic [7:0]         vx_r, vx_nxt;
  logic [7:0]         vy_r, vy_nxt;
  logic [7:0]         res_r, res_nxt;
  logic [7:0]         sprite_r, sprite_nxt;
  logic               coll_r, coll_nxt;
  logic               chg_r, chg_nxt;
  logic               bad_r, bad_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]         bcd_h_r, bcd_h_nxt;
  logic [6:0]         bcd_r_r, bcd_r_nxt;
  logic [3:0]         bcd_t_r, bcd_t_nxt;
  logic [7:0]         mdata_r, mdata_nxt;
  logic [SCREEN_W-1:0] row_r, row_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         o_mem_r, o_mem_nxt;
  logic [SCREEN_W-1:0] o_row_r, o_row_nxt;
  logic [ADDR_W-1:0]  o_pc_r, o_pc_nxt;
  logic [15:0]        o_opc_r, o_opc_nxt;
  logic [7:0]         o_flag_r, o_flag_nxt;
  logic               o_chg_r, o_chg_nxt;
  logic               o_snd_r, o_snd_nxt;
  logic               o_bad_r, o_bad_nxt;

  // memory, display, alu and register-file ports
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [7:0]         mem_wdata, mem_rdata;
  logic               disp_we;
  logic [ROW_W-1:0]   disp_addr;
  logic [SCREEN_W-1:0] disp_wdata, disp_rdata;
  alu_op_t            alu_op;
  logic [15:0]        alu_a, alu_b, alu_y;
  logic               alu_zero;
  logic               rf_we;
  logic [3:0]         rf_waddr, rf_raddr;
  logic [7:0]         rf_wdata, rf_rdata;
  logic               stk_we;

  // decode fields
  grp_t               grp;
  logic [3:0]         fx, fy, fn;
  logic [7:0]         nn;
  logic [ADDR_W-1:0]  nnn;
  logic [SP_W-1:0]    sp_inc, sp_dec;
  logic [13:0]        bcd_hprod;
  logic [14:0]        bcd_tprod;
  logic [SCREEN_W-1:0] draw_mask;
  logic               key_pressed;
  logic [7:0]         vx_eff, vy_eff;

  assign grp  = grp_t'(opc_r[15:12]);
  assign fx   = opc_r[11:8];
  assign fy   = opc_r[7:4];
  assign fn   = opc_r[3:0];
  assign nn   = opc_r[7:0];
  assign nnn  = opc_r[ADDR_W-1:0];

  // second half of a flag op sees the new VF when an operand is register F
  assign vx_eff = (fx == 4'hF) ? rf_r[15] : vx_r;
  assign vy_eff = (fy == 4'hF) ? rf_r[15] : vy_r;

  // stack pointer wraps modulo the stack depth in both directions
  assign sp_inc = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
  assign sp_dec = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;

  // decimal digits by reciprocal multiply, exact for 8-bit values
  assign bcd_hprod = {6'd0, vx_r} * 14'd41;
  assign bcd_tprod = {8'd0, bcd_r_r} * 15'd205;

  assign draw_mask   = sprite_mask(sprite_r, vx_r[COL_W-1:0]);
  assign key_pressed = keys_r[vx_r[3:0]];
  assign rf_rdata    = rf_r[rf_raddr];

  assign in_ready = (state_r == ST_IDLE);

  c8_ram #(.AW(ADDR_W), .DW(8)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  c8_ram #(.AW(ROW_W), .DW(SCREEN_W)) u_disp (
    .clk   (clk),
    .we    (disp_we),
    .addr  (disp_addr),
    .wdata (disp_wdata),
    .rdata (disp_rdata)
  );

  // one shared adder/logic unit for addresses, pc steps and register math
  c8_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .y    (alu_y),
    .zero (alu_zero)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    keys_nxt      = keys_r;
    rnd_nxt       = rnd_r;
    pc_nxt        = pc_r;
    index_nxt     = index_r;
    sp_nxt        = sp_r;
    delay_nxt     = delay_r;
    sound_nxt     = sound_r;
    opc_nxt       = opc_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    res_nxt       = res_r;
    sprite_nxt    = sprite_r;
    coll_nxt      = coll_r;
    chg_nxt       = chg_r;
    bad_nxt       = bad_r;
    cnt_nxt       = cnt_r;
    bcd_h_nxt     = bcd_h_r;
    bcd_r_nxt     = bcd_r_r;
    bcd_t_nxt     = bcd_t_r;
    mdata_nxt     = mdata_r;
    row_nxt       = row_r;
    o_mem_nxt     = o_mem_r;
    o_row_nxt     = o_row_r;
    o_pc_nxt      = o_pc_r;
    o_opc_nxt     = o_opc_r;
    o_flag_nxt    = o_flag_r;
    o_chg_nxt     = o_chg_r;
    o_snd_nxt     = o_snd_r;
    o_bad_nxt     = o_bad_r;
    // a waiting result leaves on its transfer
    out_valid_nxt = out_valid_r && !out_ready;

    mem_we     = 1'b0;
    mem_addr   = cnt_r;
    mem_wdata  = 8'd0;
    disp_we    = 1'b0;
    disp_addr  = cnt_r[ROW_W-1:0];
    disp_wdata = '0;
    alu_op     = ALU_ADD;
    alu_a      = 16'd0;
    alu_b      = 16'd0;
    rf_we      = 1'b0;
    rf_waddr   = fx;
    rf_wdata   = res_r;
    rf_raddr   = fx;
    stk_we     = 1'b0;

    unique case (state_r)
      // clearing pass: font into the low bytes, zero elsewhere, blank the display
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = (cnt_r < ADDR_W'(FONT_BYTES)) ? FONT[cnt_r[FONT_IDX_W-1:0]] : 8'd0;
        disp_we   = (cnt_r < ADDR_W'(SCREEN_H));
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(MEM_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = item_op_t'(in_op);
          addr_nxt  = in_address;
          wdata_nxt = in_write_data;
          keys_nxt  = in_keys;
          rnd_nxt   = in_random_byte;
          opc_nxt   = 16'd0;
          chg_nxt   = 1'b0;
          bad_nxt   = 1'b0;
          mdata_nxt = 8'd0;
          row_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_START;
        end
      end

      ST_START: begin
        unique case (op_r)
          OP_WRITE_MEM: begin
            mem_we    = 1'b1;
            mem_addr  = addr_r;
            mem_wdata = wdata_r;
            state_nxt = ST_DONE;
          end
          OP_READ_MEM: begin
            mem_addr  = addr_r;
            state_nxt = ST_CAPTURE;
          end
          OP_READ_ROW: begin
            disp_addr = addr_r[ROW_W-1:0];
            state_nxt = ST_CAPTURE;
          end
          OP_EXECUTE: begin
            mem_addr  = pc_r;
            state_nxt = ST_FETCH_HI;
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_CAPTURE: begin
        if (op_r == OP_READ_MEM) begin
          mdata_nxt = mem_rdata;
        end else begin
          row_nxt = disp_rdata;
        end
        state_nxt = ST_DONE;
      end

      // instruction word is big endian: high byte at pc
      ST_FETCH_HI: begin
        alu_a     = {4'd0, pc_r};
        alu_b     = 16'd1;
        mem_addr  = alu_y[ADDR_W-1:0];
        opc_nxt   = {mem_rdata, opc_r[7:0]};
        state_nxt = ST_FETCH_LO;
      end

      ST_FETCH_LO: begin
        alu_a     = {4'd0, pc_r};
        alu_b     = 16'd2;
        pc_nxt    = alu_y[ADDR_W-1:0];
        opc_nxt   = {opc_r[15:8], mem_rdata};
        state_nxt = ST_READ_VX;
      end

      ST_READ_VX: begin
        vx_nxt    = rf_rdata;
        state_nxt = ST_READ_VY;
      end

      // BNNN takes V0 through the second operand slot
      ST_READ_VY: begin
        rf_raddr  = (grp == GRP_JP_V0) ? 4'd0 : fy;
        vy_nxt    = rf_rdata;
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        state_nxt = ST_FINISH;
        unique case (grp)
          GRP_SYS: begin
            if (opc_r == OPC_CLS) begin
              chg_nxt   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_CLS;
            end else if (opc_r == OPC_RET) begin
              sp_nxt = sp_dec;
              pc_nxt = stack_r[sp_dec];
            end
          end
          GRP_JP: pc_nxt = nnn;
          GRP_CALL: begin
            stk_we = 1'b1;
            sp_nxt = sp_inc;
            pc_nxt = nnn;
          end
          GRP_SE_IMM: begin
            alu_op = ALU_SUB;
            alu_a  = {8'd0, vx_r};
            alu_b  = {8'd0, nn};
            if (alu_zero) state_nxt = ST_SKIP;
          end
          GRP_SNE_IMM: begin
            alu_op = ALU_SUB;
            alu_a  = {8'd0, vx_r};
            alu_b  = {8'd0, nn};
            if (!alu_zero) state_nxt = ST_SKIP;
          end
          GRP_SE_REG: begin
            alu_op = ALU_SUB;
            alu_a  = {8'd0, vx_r};
            alu_b  = {8'd0, vy_r};
            if (alu_zero) state_nxt = ST_SKIP;
          end
          GRP_SNE_REG: begin
            alu_op = ALU_SUB;
            alu_a  = {8'd0, vx_r};
            alu_b  = {8'd0, vy_r};
            if (!alu_zero) state_nxt = ST_SKIP;
          end
          GRP_LD_IMM: begin
            rf_we    = 1'b1;
            rf_wdata = nn;
          end
          GRP_ADD_IMM: begin
            alu_a    = {8'd0, vx_r};
            alu_b    = {8'd0, nn};
            rf_we    = 1'b1;
            rf_wdata = alu_y[7:0];
          end
          GRP_ALU: begin
            alu_a = {8'd0, vx_r};
            alu_b = {8'd0, vy_r};
            // flag ops write VF now and VX next cycle, so X=F ends with the result
            case (fn)
              SUB_MOV: begin
                rf_we    = 1'b1;
                rf_wdata = vy_r;
              end
              SUB_OR: begin
                alu_op   = ALU_OR;
                rf_we    = 1'b1;
                rf_wdata = alu_y[7:0];
              end
              SUB_AND: begin
                alu_op   = ALU_AND;
                rf_we    = 1'b1;
                rf_wdata = alu_y[7:0];
              end
              SUB_XOR: begin
                alu_op   = ALU_XOR;
                rf_we    = 1'b1;
                rf_wdata = alu_y[7:0];
              end
              SUB_ADD: begin
                rf_we     = 1'b1;
                rf_waddr  = 4'hF;
                rf_wdata  = {7'd0, alu_y[8]};
                res_nxt   = alu_y[7:0];
                state_nxt = ST_WRITE_VX;
              end
              SUB_SUB: begin
                alu_op    = ALU_SUB;
                rf_we     = 1'b1;
                rf_waddr  = 4'hF;
                rf_wdata  = {7'd0, !alu_y[15]};
                res_nxt   = alu_y[7:0];
                state_nxt = ST_WRITE_VX;
              end
              SUB_SHR: begin
                alu_op    = ALU_SHR;
                rf_we     = 1'b1;
                rf_waddr  = 4'hF;
                rf_wdata  = {7'd0, vx_r[0]};
                res_nxt   = alu_y[7:0];
                state_nxt = ST_WRITE_VX;
              end
              SUB_RSUB: begin
                alu_op    = ALU_SUB;
                alu_a     = {8'd0, vy_r};
                alu_b     = {8'd0, vx_r};
                rf_we     = 1'b1;
                rf_waddr  = 4'hF;
                rf_wdata  = {7'd0, !alu_y[15]};
                res_nxt   = alu_y[7:0];
                state_nxt = ST_WRITE_VX;
              end
              SUB_SHL: begin
                alu_op    = ALU_SHL;
                rf_we     = 1'b1;
                rf_waddr  = 4'hF;
                rf_wdata  = {7'd0, vx_r[7]};
                res_nxt   = alu_y[7:0];
                state_nxt = ST_WRITE_VX;
              end
              default: ;
            endcase
          end
          GRP_LD_I: index_nxt = {4'd0, nnn};
          GRP_JP_V0: begin
            alu_a  = {4'd0, nnn};
            alu_b  = {8'd0, vy_r};
            pc_nxt = alu_y[ADDR_W-1:0];
          end
          GRP_RND: begin
            rf_we    = 1'b1;
            rf_wdata = rnd_r & nn;
          end
          GRP_DRAW: begin
            // coordinates are already latched, so VF can clear first
            rf_we    = 1'b1;
            rf_waddr = 4'hF;
            rf_wdata = 8'd0;
            cnt_nxt  = '0;
            coll_nxt = 1'b0;
            chg_nxt  = 1'b1;
            state_nxt = (fn == 4'd0) ? ST_DRAW_FLAG : ST_DRAW_FETCH;
          end
          GRP_KEY: begin
            if ((nn == KEY_DOWN && key_pressed) || (nn == KEY_UP && !key_pressed)) begin
              state_nxt = ST_SKIP;
            end
          end
          GRP_MISC: begin
            case (nn)
              FX_GET_DELAY: begin
                rf_we    = 1'b1;
                rf_wdata = delay_r;
              end
              FX_SET_DELAY: delay_nxt = vx_r;
              FX_SET_SOUND: sound_nxt = vx_r;
              FX_ADD_INDEX: begin
                alu_a     = index_r;
                alu_b     = {8'd0, vx_r};
                index_nxt = alu_y;
              end
              FX_FONT: begin
                // five bytes per glyph: 4v + v
                alu_a     = {6'd0, vx_r, 2'd0};
                alu_b     = {8'd0, vx_r};
                index_nxt = alu_y;
              end
              FX_BCD: state_nxt = ST_BCD_H;
              FX_STORE: begin
                cnt_nxt   = '0;
                state_nxt = ST_STORE;
              end
              FX_LOAD: begin
                cnt_nxt   = '0;
                state_nxt = ST_LOAD_RD;
              end
              default: ;
            endcase
          end
          default: bad_nxt = 1'b1;
        endcase
      end

      // VF already holds the flag; subtract and shift results read it back
      ST_WRITE_VX: begin
        rf_we     = 1'b1;
        rf_wdata  = res_r;
        alu_a     = {8'd0, vx_eff};
        alu_b     = {8'd0, vy_eff};
        case (fn)
          SUB_SUB: begin
            alu_op   = ALU_SUB;
            rf_wdata = alu_y[7:0];
          end
          SUB_SHR: begin
            alu_op   = ALU_SHR;
            rf_wdata = alu_y[7:0];
          end
          SUB_RSUB: begin
            alu_op   = ALU_SUB;
            alu_a    = {8'd0, vy_eff};
            alu_b    = {8'd0, vx_eff};
            rf_wdata = alu_y[7:0];
          end
          SUB_SHL: begin
            alu_op   = ALU_SHL;
            rf_wdata = alu_y[7:0];
          end
          default: ;
        endcase
        state_nxt = ST_FINISH;
      end

      ST_SKIP: begin
        alu_a     = {4'd0, pc_r};
        alu_b     = 16'd2;
        pc_nxt    = alu_y[ADDR_W-1:0];
        state_nxt = ST_FINISH;
      end

      ST_CLS: begin
        disp_we   = 1'b1;
        disp_addr = cnt_r[ROW_W-1:0];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[ROW_W-1:0] == ROW_W'(SCREEN_H - 1)) begin
          state_nxt = ST_FINISH;
        end
      end

      // sprite row: fetch byte at I+r, read display row vy+r, xor back
      ST_DRAW_FETCH: begin
        alu_a     = index_r;
        alu_b     = {4'd0, cnt_r};
        mem_addr  = alu_y[ADDR_W-1:0];
        state_nxt = ST_DRAW_ROW;
      end

      ST_DRAW_ROW: begin
        sprite_nxt = mem_rdata;
        alu_a      = {8'd0, vy_r};
        alu_b      = {4'd0, cnt_r};
        disp_addr  = alu_y[ROW_W-1:0];
        state_nxt  = ST_DRAW_XOR;
      end

      ST_DRAW_XOR: begin
        alu_a      = {8'd0, vy_r};
        alu_b      = {4'd0, cnt_r};
        disp_addr  = alu_y[ROW_W-1:0];
        disp_we    = 1'b1;
        disp_wdata = disp_rdata ^ draw_mask;
        coll_nxt   = coll_r | (|(disp_rdata & draw_mask));
        cnt_nxt    = cnt_r + 1'b1;
        state_nxt  = (cnt_r[3:0] + 4'd1 == fn) ? ST_DRAW_FLAG : ST_DRAW_FETCH;
      end

      ST_DRAW_FLAG: begin
        rf_we     = 1'b1;
        rf_waddr  = 4'hF;
        rf_wdata  = {7'd0, coll_r};
        state_nxt = ST_FINISH;
      end

      ST_BCD_H: begin
        bcd_h_nxt = bcd_hprod[13:12];
        state_nxt = ST_BCD_R;
      end

      ST_BCD_R: begin
        res_nxt   = vx_r - ({6'd0, bcd_h_r} * 8'd100);
        bcd_r_nxt = res_nxt[6:0];
        alu_a     = index_r;
        alu_b     = 16'd0;
        mem_we    = 1'b1;
        mem_addr  = alu_y[ADDR_W-1:0];
        mem_wdata = {6'd0, bcd_h_r};
        state_nxt = ST_BCD_T;
      end

      ST_BCD_T: begin
        bcd_t_nxt = bcd_tprod[14:11];
        state_nxt = ST_BCD_WT;
      end

      ST_BCD_WT: begin
        alu_a     = index_r;
        alu_b     = 16'd1;
        mem_we    = 1'b1;
        mem_addr  = alu_y[ADDR_W-1:0];
        mem_wdata = {4'd0, bcd_t_r};
        state_nxt = ST_BCD_WO;
      end

      ST_BCD_WO: begin
        alu_a     = index_r;
        alu_b     = 16'd2;
        mem_we    = 1'b1;
        mem_addr  = alu_y[ADDR_W-1:0];
        mem_wdata = {1'b0, bcd_r_r} - ({4'd0, bcd_t_r} * 8'd10);
        state_nxt = ST_FINISH;
      end

      ST_STORE: begin
        rf_raddr  = cnt_r[3:0];
        alu_a     = index_r;
        alu_b     = {4'd0, cnt_r};
        mem_we    = 1'b1;
        mem_addr  = alu_y[ADDR_W-1:0];
        mem_wdata = rf_rdata;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[3:0] == fx) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_LOAD_RD: begin
        alu_a     = index_r;
        alu_b     = {4'd0, cnt_r};
        mem_addr  = alu_y[ADDR_W-1:0];
        state_nxt = ST_LOAD_WR;
      end

      ST_LOAD_WR: begin
        rf_we    = 1'b1;
        rf_waddr = cnt_r[3:0];
        rf_wdata = mem_rdata;
        cnt_nxt  = cnt_r + 1'b1;
        state_nxt = (cnt_r[3:0] == fx) ? ST_FINISH : ST_LOAD_RD;
      end

      // timers tick once per executed instruction, after it
      ST_FINISH: begin
        if (delay_r != 8'd0) delay_nxt = delay_r - 8'd1;
        if (sound_r != 8'd0) sound_nxt = sound_r - 8'd1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_mem_nxt     = mdata_r;
          o_row_nxt     = row_r;
          o_pc_nxt      = pc_r;
          o_opc_nxt     = opc_r;
          o_flag_nxt    = rf_r[15];
          o_chg_nxt     = chg_r;
          o_snd_nxt     = (sound_r != 8'd0);
          o_bad_nxt     = bad_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      pc_r        <= PC_RESET;
      index_r     <= 16'd0;
      sp_r        <= '0;
      delay_r     <= 8'd0;
      sound_r     <= 8'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        rf_r[i] <= 8'd0;
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pc_r        <= pc_nxt;
      index_r     <= index_nxt;
      sp_r        <= sp_nxt;
      delay_r     <= delay_nxt;
      sound_r     <= sound_nxt;
      out_valid_r <= out_valid_nxt;
      if (rf_we) begin
        rf_r[rf_waddr] <= rf_wdata;
      end
      if (stk_we) begin
        stack_r[sp_r] <= pc_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    keys_r   <= keys_nxt;
    rnd_r    <= rnd_nxt;
    opc_r    <= opc_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    res_r    <= res_nxt;
    sprite_r <= sprite_nxt;
    coll_r   <= coll_nxt;
    chg_r    <= chg_nxt;
    bad_r    <= bad_nxt;
    bcd_h_r  <= bcd_h_nxt;
    bcd_r_r  <= bcd_r_nxt;
    bcd_t_r  <= bcd_t_nxt;
    mdata_r  <= mdata_nxt;
    row_r    <= row_nxt;
    o_mem_r  <= o_mem_nxt;
    o_row_r  <= o_row_nxt;
    o_pc_r   <= o_pc_nxt;
    o_opc_r  <= o_opc_nxt;
    o_flag_r <= o_flag_nxt;
    o_chg_r  <= o_chg_nxt;
    o_snd_r  <= o_snd_nxt;
    o_bad_r  <= o_bad_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_mem_data        = o_mem_r;
  assign out_row_pixels      = o_row_r;
  assign out_prog_counter    = o_pc_r;
  assign out_executed_opcode = o_opc_r;
  assign out_flag_value      = o_flag_r;
  assign out_screen_changed  = o_chg_r;
  assign out_sound_active    = o_snd_r;
  assign out_bad_opcode      = o_bad_r;

  // every top nibble decodes, so no result may carry the error bit
  a_no_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_bad_opcode)
    else $error("bad opcode flagged");

  // screen only changes for a clear or a draw
  a_chg_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_screen_changed) |->
      ((out_executed_opcode == OPC_CLS) || (out_executed_opcode[15:12] == GRP_DRAW)))
    else $error("screen change without clear or draw");

  // stack pointer moves only in the execute step
  a_sp_move: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (sp_r != $past(sp_r))) |-> ($past(state_r) == ST_EXEC))
    else $error("stack pointer moved outside execute");

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import c8_pkg::*;

  typedef struct packed {
    logic [7:0]  mem_data;
    logic [63:0] row_pixels;
    logic [11:0] prog_counter;
    logic [15:0] executed_opcode;
    logic [7:0]  flag_value;
    logic        screen_changed;
    logic        sound_active;
    logic        bad_opcode;
  } core_result_t;

  // holds the predicted results in transfer order and checks each output against the oldest
  class result_tracker;
    core_result_t pending_results[$];
    int mismatches;
    int orphans;

    function new();
      mismatches = 0;
      orphans = 0;
    endfunction

    function void note_item(core_result_t r);
      pending_results.push_back(r);
    endfunction

    function void check_result(core_result_t got);
      core_result_t want;
      if (pending_results.size() == 0) begin
        orphans++;
        $display("unexpected result transfer: %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: mem %h/%h row %h/%h pc %h/%h opc %h/%h vf %h/%h chg %b/%b snd %b/%b bad %b/%b",
                   want.mem_data, got.mem_data, want.row_pixels, got.row_pixels,
                   want.prog_counter, got.prog_counter, want.executed_opcode,
                   got.executed_opcode, want.flag_value, got.flag_value,
                   want.screen_changed, got.screen_changed, want.sound_active,
                   got.sound_active, want.bad_opcode, got.bad_opcode);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [11:0] in_address;
  logic [7:0]  in_write_data;
  logic [15:0] in_keys;
  logic [7:0]  in_random_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_mem_data;
  logic [63:0] out_row_pixels;
  logic [11:0] out_prog_counter;
  logic [15:0] out_executed_opcode;
  logic [7:0]  out_flag_value;
  logic        out_screen_changed;
  logic        out_sound_active;
  logic        out_bad_opcode;

  chip8_instruction_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_keys            (in_keys),
    .in_random_byte     (in_random_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_mem_data       (out_mem_data),
    .out_row_pixels     (out_row_pixels),
    .out_prog_counter   (out_prog_counter),
    .out_executed_opcode(out_executed_opcode),
    .out_flag_value     (out_flag_value),
    .out_screen_changed (out_screen_changed),
    .out_sound_active   (out_sound_active),
    .out_bad_opcode     (out_bad_opcode)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow copy of the interpreter state
  logic [7:0]  shadow_mem [MEM_BYTES];
  logic [7:0]  vreg [16];
  logic [15:0] index_shadow;
  logic [11:0] pc_shadow;
  logic [3:0]  sp_shadow;
  logic [11:0] stack_shadow [16];
  logic [7:0]  delay_shadow;
  logic [7:0]  sound_shadow;
  logic [63:0] screen_shadow [SCREEN_H];

  result_tracker tracker;
  int  items_done;
  bit  calm;
  bit  timed_out;
  int  quiet_cycles;

  function automatic void clear_shadow();
    for (int a = 0; a < MEM_BYTES; a++) shadow_mem[a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
    for (int r = 0; r < 16; r++) begin
      vreg[r] = '0;
      stack_shadow[r] = '0;
    end
    for (int r = 0; r < SCREEN_H; r++) screen_shadow[r] = '0;
    index_shadow = '0;
    pc_shadow = PC_RESET;
    sp_shadow = '0;
    delay_shadow = '0;
    sound_shadow = '0;
  endfunction

  function automatic void skip_when(bit c);
    if (c) pc_shadow = pc_shadow + 12'd2;
  endfunction

  // runs one instruction word on the shadow state, returns 1 if the screen was touched
  function automatic bit run_instruction(logic [15:0] w, logic [15:0] keys, logic [7:0] rnd);
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  nn;
    logic [8:0]  total;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [7:0]  bits;
    logic [4:0]  row;
    logic [5:0]  col;
    logic [11:0] a;
    bit          drew;
    x = w[11:8];
    y = w[7:4];
    nn = w[7:0];
    drew = 0;
    case (grp_t'(w[15:12]))
      GRP_SYS: begin
        if (w == OPC_CLS) begin
          for (int r = 0; r < SCREEN_H; r++) screen_shadow[r] = '0;
          drew = 1;
        end else if (w == OPC_RET) begin
          sp_shadow = sp_shadow - 4'd1;
          pc_shadow = stack_shadow[sp_shadow];
        end
      end
      GRP_JP: pc_shadow = w[11:0];
      GRP_CALL: begin
        stack_shadow[sp_shadow] = pc_shadow;
        sp_shadow = sp_shadow + 4'd1;
        pc_shadow = w[11:0];
      end
      GRP_SE_IMM:  skip_when(vreg[x] == nn);
      GRP_SNE_IMM: skip_when(vreg[x] != nn);
      GRP_SE_REG:  skip_when(vreg[x] == vreg[y]);
      GRP_LD_IMM:  vreg[x] = nn;
      GRP_ADD_IMM: vreg[x] = vreg[x] + nn;
      GRP_ALU: begin
        // flag goes first, then vx from whatever the registers hold by then
        case (w[3:0])
          SUB_MOV: vreg[x] = vreg[y];
          SUB_OR:  vreg[x] = vreg[x] | vreg[y];
          SUB_AND: vreg[x] = vreg[x] & vreg[y];
          SUB_XOR: vreg[x] = vreg[x] ^ vreg[y];
          SUB_ADD: begin
            total = {1'b0, vreg[x]} + {1'b0, vreg[y]};
            vreg[15] = {7'd0, total[8]};
            vreg[x] = total[7:0];
          end
          SUB_SUB: begin
            vreg[15] = {7'd0, vreg[x] >= vreg[y]};
            vreg[x] = vreg[x] - vreg[y];
          end
          SUB_SHR: begin
            vreg[15] = {7'd0, vreg[x][0]};
            vreg[x] = vreg[x] >> 1;
          end
          SUB_RSUB: begin
            vreg[15] = {7'd0, vreg[y] >= vreg[x]};
            vreg[x] = vreg[y] - vreg[x];
          end
          SUB_SHL: begin
            vreg[15] = {7'd0, vreg[x][7]};
            vreg[x] = vreg[x] << 1;
          end
          default: ;
        endcase
      end
      GRP_SNE_REG: skip_when(vreg[x] != vreg[y]);
      GRP_LD_I:    index_shadow = {4'd0, w[11:0]};
      GRP_JP_V0:   pc_shadow = w[11:0] + {4'd0, vreg[0]};
      GRP_RND:     vreg[x] = rnd & nn;
      GRP_DRAW: begin
        // coordinates are latched before vf is cleared
        px = vreg[x];
        py = vreg[y];
        vreg[15] = '0;
        for (int r = 0; r < w[3:0]; r++) begin
          a = index_shadow[11:0] + 12'(r);
          bits = shadow_mem[a];
          row = 5'(py + 8'(r));
          for (int c = 0; c < 8; c++) begin
            if (bits[7-c]) begin
              col = 6'(px + 8'(c));
              if (screen_shadow[row][col]) vreg[15] = 8'd1;
              screen_shadow[row][col] = ~screen_shadow[row][col];
            end
          end
        end
        drew = 1;
      end
      GRP_KEY: begin
        if (nn == KEY_DOWN) skip_when(keys[vreg[x][3:0]]);
        else if (nn == KEY_UP) skip_when(!keys[vreg[x][3:0]]);
      end
      default: begin
        case (nn)
          FX_GET_DELAY: vreg[x] = delay_shadow;
          FX_SET_DELAY: delay_shadow = vreg[x];
          FX_SET_SOUND: sound_shadow = vreg[x];
          FX_ADD_INDEX: index_shadow = index_shadow + {8'd0, vreg[x]};
          FX_FONT:      index_shadow = {8'd0, vreg[x]} * 16'd5;
          FX_BCD: begin
            a = index_shadow[11:0];
            shadow_mem[a] = vreg[x] / 8'd100;
            shadow_mem[a + 12'd1] = (vreg[x] / 8'd10) % 8'd10;
            shadow_mem[a + 12'd2] = vreg[x] % 8'd10;
          end
          FX_STORE:
            for (int i = 0; i <= x; i++) shadow_mem[index_shadow[11:0] + 12'(i)] = vreg[i];
          FX_LOAD:
            for (int i = 0; i <= x; i++) vreg[i] = shadow_mem[index_shadow[11:0] + 12'(i)];
          default: ;
        endcase
      end
    endcase
    return drew;
  endfunction

  function automatic core_result_t predict_item(item_op_t op, logic [11:0] addr,
                                                logic [7:0] wdata, logic [15:0] keys,
                                                logic [7:0] rnd);
    core_result_t r;
    logic [15:0]  w;
    r = '0;
    case (op)
      OP_WRITE_MEM: shadow_mem[addr] = wdata;
      OP_EXECUTE: begin
        w = {shadow_mem[pc_shadow], shadow_mem[pc_shadow + 12'd1]};
        pc_shadow = pc_shadow + 12'd2;
        r.screen_changed = run_instruction(w, keys, rnd);
        r.executed_opcode = w;
        if (delay_shadow != 0) delay_shadow--;
        if (sound_shadow != 0) sound_shadow--;
      end
      OP_READ_ROW: r.row_pixels = screen_shadow[addr[4:0]];
      default: r.mem_data = shadow_mem[addr];
    endcase
    r.prog_counter = pc_shadow;
    r.flag_value = vreg[15];
    r.sound_active = (sound_shadow != 0);
    return r;
  endfunction

  // one input transfer, with a random gap ahead of it outside the calm stretch
  task automatic send_item(item_op_t op, logic [11:0] addr, logic [7:0] wdata,
                           logic [15:0] keys, logic [7:0] rnd);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_address     <= addr;
    in_write_data  <= wdata;
    in_keys        <= keys;
    in_random_byte <= rnd;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(predict_item(op, addr, wdata, keys, rnd));
    items_done++;
  endtask

  // loads the word at the current pc and executes it
  task automatic run_word(logic [15:0] w);
    send_item(OP_WRITE_MEM, pc_shadow, w[15:8], 16'($urandom), 8'($urandom));
    send_item(OP_WRITE_MEM, pc_shadow + 12'd1, w[7:0], 16'($urandom), 8'($urandom));
    send_item(OP_EXECUTE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    logic [7:0]  fx_codes [10];
    logic [3:0]  alu_subs [9];
    fx_codes = '{FX_GET_DELAY, FX_SET_DELAY, FX_SET_SOUND, FX_ADD_INDEX, FX_FONT,
                 FX_BCD, FX_STORE, FX_LOAD, 8'($urandom), 8'($urandom)};
    alu_subs = '{SUB_MOV, SUB_OR, SUB_AND, SUB_XOR, SUB_ADD, SUB_SUB, SUB_SHR,
                 SUB_RSUB, SUB_SHL};
    w = 16'($urandom);
    case (grp_t'(w[15:12]))
      GRP_SYS: begin
        case ($urandom_range(3))
          0: w = OPC_CLS;
          1: w = OPC_RET;
          default: ;
        endcase
      end
      GRP_ALU:
        if ($urandom_range(9) != 0) w[3:0] = alu_subs[$urandom_range(8)];
      GRP_KEY:
        case ($urandom_range(4))
          0, 1: w[7:0] = KEY_DOWN;
          2, 3: w[7:0] = KEY_UP;
          default: ;
        endcase
      GRP_MISC: w[7:0] = fx_codes[$urandom_range(9)];
      default: ;
    endcase
    return w;
  endfunction

  // result side: random stalls, one long hold-off, and always ready in the calm stretch
  initial begin : result_side
    bit held;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_done >= 200) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result('{out_mem_data, out_row_pixels, out_prog_counter,
                             out_executed_opcode, out_flag_value, out_screen_changed,
                             out_sound_active, out_bad_opcode});
  end

  // watchdog over cycles with no transfer on either side; covers the reset sweep
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    tracker = new();
    items_done = 0;
    calm = 0;
    timed_out = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_WRITE_MEM;
    in_address = '0;
    in_write_data = '0;
    in_keys = '0;
    in_random_byte = '0;
    clear_shadow();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: font and memory edges, row wrap, sprite wrap, flag order, fetch wrap
    send_item(OP_READ_MEM, 12'h000, 8'h00, 16'h0000, 8'h00);
    send_item(OP_READ_MEM, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(OP_WRITE_MEM, 12'hFFF, 8'hA5, 16'h0000, 8'h00);
    send_item(OP_READ_MEM, 12'hFFF, 8'h00, 16'hFFFF, 8'h00);
    run_word(16'h603C);
    run_word(16'h611F);
    run_word(16'hD01F);
    send_item(OP_READ_ROW, 12'hFFF, 8'h00, 16'h0000, 8'h00);
    run_word(16'h8FF4);
    run_word(16'h1FFF);
    run_word(OPC_CLS);

    // random: mostly load-and-execute, some raw reads and writes
    while (items_done < 950) begin
      calm = (items_done >= 450 && items_done < 600);
      if ($urandom_range(9) < 7) begin
        run_word(pick_word());
      end else begin
        case ($urandom_range(2))
          0: send_item(OP_WRITE_MEM, 12'($urandom), 8'($urandom), 16'($urandom),
                       8'($urandom));
          1: send_item(OP_READ_ROW, 12'($urandom), 8'($urandom), 16'($urandom),
                       8'($urandom));
          default: send_item(OP_READ_MEM, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
        endcase
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.orphans == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
